// ===== hdl/ncb_pkg.sv =====
// Shared types and constants for the neighbor contrast beta block.
package ncb_pkg;

  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 2048;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned GeoW      = 12;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned PixW      = 3 * ChanW;
  localparam int unsigned DistW     = 2 * ChanW + 2;
  localparam int unsigned SumW      = 56;
  localparam int unsigned CntW      = 40;
  localparam int unsigned BetaW     = 48;
  localparam int unsigned FracShift = 31;
  localparam int unsigned DivSteps  = CntW + FracShift;
  localparam int unsigned SatSteps  = DivSteps - BetaW;
  localparam int unsigned StepW     = $clog2(DivSteps);

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SKIP   = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAIR,
    S_FIN,
    S_START,
    S_DIV,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PAIR_LEFT,
    PAIR_UPLEFT,
    PAIR_UP,
    PAIR_UPRIGHT
  } pair_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             final_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [BetaW-1:0] beta_value;
    logic [CntW-1:0]  pair_total;
    logic [SumW-1:0]  squared_sum;
    logic             beta_saturated;
  } beta_out_t;

  typedef struct packed {
    logic [BetaW-1:0] quot;
    logic             sat;
    logic             done;
  } div_status_t;

endpackage

// ===== hdl/ncb_divider.sv =====
// Restoring divider: floor(count * 2^31 / sum), one quotient bit per cycle.
module ncb_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ncb_pkg::CntW-1:0]    count_i,
  input  logic [ncb_pkg::SumW-1:0]    sum_i,
  output ncb_pkg::div_status_t        status_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [ncb_pkg::StepW-1:0]    step_q, step_d;
  logic [ncb_pkg::CntW-1:0]     num_q, num_d;
  logic [ncb_pkg::SumW-1:0]     den_q, den_d;
  logic [ncb_pkg::SumW-1:0]     rem_q, rem_d;
  logic [ncb_pkg::BetaW-1:0]    quo_q, quo_d;
  logic                         sat_q, sat_d;
  logic [ncb_pkg::SumW:0]       shifted;
  logic [ncb_pkg::SumW+1:0]     trial;
  logic                         qbit;

  // shift the next dividend bit in, subtract when it fits
  always_comb begin
    shifted = {rem_q, num_q[ncb_pkg::CntW-1]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
    qbit    = ~trial[ncb_pkg::SumW+1];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    sat_d  = sat_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      num_d  = count_i;
      den_d  = sum_i;
      rem_d  = '0;
      quo_d  = '0;
      sat_d  = 1'b0;
    end else if (busy_q) begin
      num_d = {num_q[ncb_pkg::CntW-2:0], 1'b0};
      rem_d = qbit ? trial[ncb_pkg::SumW-1:0] : shifted[ncb_pkg::SumW-1:0];
      quo_d = {quo_q[ncb_pkg::BetaW-2:0], qbit};
      // quotient bits above the Q17.31 range mean saturation
      if (qbit && (step_q < ncb_pkg::StepW'(ncb_pkg::SatSteps))) begin
        sat_d = 1'b1;
      end
      step_d = step_q + 1'b1;
      if (step_q == ncb_pkg::StepW'(ncb_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
  end

  assign status_o.quot = quo_q;
  assign status_o.sat  = sat_q;
  assign status_o.done = done_q;

endmodule

// ===== hdl/neighbor_contrast_beta.sv =====
// Top level: neighbor color contrast accumulation and beta computation.
// Each pixel steps through accept/memory read, four neighbor pair states, finish/write-back.
// A new pixel is taken only after the last one's finish state, set by the one-pair-per-cycle accumulate loop.
// A final pixel then passes start, 71 divide steps, done and load (which waits on out_ready) before the result shows.
// Reset clears counters, accumulators, left and up-left neighbor registers and config to defaults.
// The row memory is not cleared; its entries are written before any value read from them is used.
module neighbor_contrast_beta (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ncb_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ncb_pkg::GeoW-1:0]        cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ncb_pkg::pix_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ncb_pkg::beta_out_t              out_data_o
);

  // configuration
  logic [ncb_pkg::GeoW-1:0] width_q, height_q;
  logic                     skip_q;
  logic [ncb_pkg::GeoW-1:0] w_eff, h_eff;

  // control
  ncb_pkg::state_e          state_q, state_d;
  ncb_pkg::pair_e           pair_q, pair_d;
  logic [ncb_pkg::ColW-1:0] col_q, col_d;
  logic [ncb_pkg::RowW-1:0] row_q, row_d;
  logic                     out_valid_q, out_valid_d;
  logic                     dist_en_q, dist_en_d;
  logic [ncb_pkg::SumW-1:0] acc_q, acc_d;
  logic [ncb_pkg::CntW-1:0] cnt_q, cnt_d;

  // payload
  logic [ncb_pkg::PixW-1:0]  pix_q;
  logic                      final_q;
  logic [ncb_pkg::PixW-1:0]  left_q, left_d;
  logic [ncb_pkg::PixW-1:0]  upleft_q, upleft_d;
  logic [ncb_pkg::PixW-1:0]  up_q, upright_q;
  logic [ncb_pkg::DistW-1:0] dist_q, dist_d;
  ncb_pkg::beta_out_t        out_q;

  logic [ncb_pkg::PixW-1:0] row_mem [ncb_pkg::MaxWidth];

  // strobes
  logic in_acc, mem_wr, div_start, load_out;

  ncb_pkg::div_status_t div_st;

  // neighbor color distance helpers
  logic [ncb_pkg::PixW-1:0]  nei;
  logic                      pair_ok;
  logic [ncb_pkg::GeoW-1:0]  x_next, y_next;
  logic [ncb_pkg::SumW:0]    acc_sum;

  function automatic logic [ncb_pkg::DistW-1:0] sq_dist(
    input logic [ncb_pkg::PixW-1:0] a,
    input logic [ncb_pkg::PixW-1:0] b
  );
    logic [ncb_pkg::ChanW-1:0]   ca, cb, d;
    logic [2*ncb_pkg::ChanW-1:0] sq;
    logic [ncb_pkg::DistW-1:0]   total;
    total = '0;
    for (int k = 0; k < 3; k++) begin
      ca    = a[k*ncb_pkg::ChanW +: ncb_pkg::ChanW];
      cb    = b[k*ncb_pkg::ChanW +: ncb_pkg::ChanW];
      d     = (ca > cb) ? (ca - cb) : (cb - ca);
      sq    = d * d;
      total = total + ncb_pkg::DistW'(sq);
    end
    return total;
  endfunction

  // geometry clamp: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (width_q == '0) begin
      w_eff = ncb_pkg::GeoW'(1);
    end else if (width_q > ncb_pkg::GeoW'(ncb_pkg::MaxWidth)) begin
      w_eff = ncb_pkg::GeoW'(ncb_pkg::MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = ncb_pkg::GeoW'(1);
    end else if (height_q > ncb_pkg::GeoW'(ncb_pkg::MaxHeight)) begin
      h_eff = ncb_pkg::GeoW'(ncb_pkg::MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ncb_pkg::GeoW'(640);
      height_q <= ncb_pkg::GeoW'(480);
      skip_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ncb_pkg::REG_WIDTH:  width_q  <= cfg_wdata_i;
        ncb_pkg::REG_HEIGHT: height_q <= cfg_wdata_i;
        ncb_pkg::REG_SKIP:   skip_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ncb_pkg::S_IDLE:  if (in_valid_i) state_d = ncb_pkg::S_PAIR;
      ncb_pkg::S_PAIR:  if (pair_q == ncb_pkg::PAIR_UPRIGHT) state_d = ncb_pkg::S_FIN;
      ncb_pkg::S_FIN:   state_d = final_q ? ncb_pkg::S_START : ncb_pkg::S_IDLE;
      ncb_pkg::S_START: state_d = ncb_pkg::S_DIV;
      ncb_pkg::S_DIV:   if (div_st.done) state_d = ncb_pkg::S_OUT;
      ncb_pkg::S_OUT:   if (!out_valid_q || out_ready_i) state_d = ncb_pkg::S_IDLE;
      default:          state_d = ncb_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = (state_q == ncb_pkg::S_IDLE);
    in_acc     = in_ready_o && in_valid_i;
    mem_wr     = (state_q == ncb_pkg::S_FIN);
    div_start  = (state_q == ncb_pkg::S_START);
    load_out   = (state_q == ncb_pkg::S_OUT) && (!out_valid_q || out_ready_i);
  end

  // neighbor pair selection, one pair per cycle in the pair state
  always_comb begin
    unique case (pair_q)
      ncb_pkg::PAIR_LEFT: begin
        nei     = left_q;
        pair_ok = (col_q != '0);
      end
      ncb_pkg::PAIR_UPLEFT: begin
        nei     = upleft_q;
        pair_ok = (row_q != '0) && (col_q != '0);
      end
      ncb_pkg::PAIR_UP: begin
        nei     = up_q;
        pair_ok = (row_q != '0);
      end
      ncb_pkg::PAIR_UPRIGHT: begin
        nei     = upright_q;
        pair_ok = (row_q != '0) && ((ncb_pkg::GeoW'(col_q) + 1'b1) < w_eff);
      end
      default: begin
        nei     = left_q;
        pair_ok = 1'b0;
      end
    endcase
    dist_en_d = (state_q == ncb_pkg::S_PAIR) && pair_ok && (pix_q != '0)
                && !(skip_q && (nei == '0));
    dist_d    = sq_dist(pix_q, nei);
    pair_d    = (state_q == ncb_pkg::S_PAIR) ? ncb_pkg::pair_e'(pair_q + 1'b1)
                                              : ncb_pkg::PAIR_LEFT;
  end

  // saturating accumulation of the registered distance, in the cycle after the pair selection
  always_comb begin
    acc_sum = {1'b0, acc_q} + ncb_pkg::SumW'(dist_q);
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    if (load_out) begin
      acc_d = '0;
      cnt_d = '0;
    end else if (dist_en_q) begin
      acc_d = acc_sum[ncb_pkg::SumW] ? '1 : acc_sum[ncb_pkg::SumW-1:0];
      cnt_d = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
    end
  end

  // raster position and neighbor registers
  always_comb begin
    x_next   = ncb_pkg::GeoW'(col_q) + 1'b1;
    y_next   = ncb_pkg::GeoW'(row_q) + 1'b1;
    col_d    = col_q;
    row_d    = row_q;
    left_d   = left_q;
    upleft_d = upleft_q;
    if (load_out) begin
      col_d    = '0;
      row_d    = '0;
      left_d   = '0;
      upleft_d = '0;
    end else if (mem_wr) begin
      left_d   = pix_q;
      upleft_d = up_q;
      if (x_next >= w_eff) begin
        col_d = '0;
        row_d = (y_next >= h_eff) ? '0 : y_next[ncb_pkg::RowW-1:0];
      end else begin
        col_d = x_next[ncb_pkg::ColW-1:0];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ncb_pkg::S_IDLE;
      pair_q      <= ncb_pkg::PAIR_LEFT;
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      upleft_q    <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      dist_en_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pair_q      <= pair_d;
      col_q       <= col_d;
      row_q       <= row_d;
      left_q      <= left_d;
      upleft_q    <= upleft_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      dist_en_q   <= dist_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    if (in_acc) begin
      pix_q   <= {in_data_i.red, in_data_i.green, in_data_i.blue};
      final_q <= in_data_i.final_pixel;
    end
    if (load_out) begin
      out_q.pair_total  <= cnt_q;
      out_q.squared_sum <= acc_q;
      if (acc_q == '0) begin
        out_q.beta_value     <= '0;
        out_q.beta_saturated <= 1'b0;
      end else begin
        out_q.beta_value     <= div_st.sat ? '1 : div_st.quot;
        out_q.beta_saturated <= div_st.sat;
      end
    end
  end

  // prior-row memory: up and up-right read at accept, center written at finish
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      up_q      <= row_mem[col_q];
      upright_q <= row_mem[col_q + 1'b1];
    end
    if (mem_wr) begin
      row_mem[col_q] <= pix_q;
    end
  end

  ncb_divider u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .count_i  (cnt_q),
    .sum_i    (acc_q),
    .status_o (div_st)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a pixel transaction always leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // a result transaction cannot be followed at once by another result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !load_out |=> !out_valid_o)
    else $error("result repeated");

  // divider completes only while the FSM waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == ncb_pkg::S_DIV)
    else $error("unexpected divider completion");

  // accumulators never decrease while pairs are processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ncb_pkg::S_PAIR |=> acc_q >= $past(acc_q) && cnt_q >= $past(cnt_q))
    else $error("accumulator went backwards");

  // pair contributions only come from the pair cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_en_q |-> $past(state_q) == ncb_pkg::S_PAIR)
    else $error("stray pair contribution");

endmodule

// ===== tb/neighbor_contrast_beta_tb.sv =====
// Self-checking testbench for neighbor_contrast_beta: pixel driver, predictor and checker.
module neighbor_contrast_beta_tb;

  localparam int unsigned CycleLimit = 3_000_000;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  logic [ncb_pkg::CfgIdxW-1:0] cfg_idx_i   = ncb_pkg::REG_WIDTH;
  logic [ncb_pkg::GeoW-1:0]    cfg_wdata_i = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  ncb_pkg::pix_in_t            in_data_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  ncb_pkg::beta_out_t          out_data_o;

  neighbor_contrast_beta u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pixels waiting to be sent and beta results waiting to be seen.
  ncb_pkg::pix_in_t   pixel_backlog[$];
  ncb_pkg::beta_out_t pending_betas[$];

  // Mirror of the configuration registers.
  logic [ncb_pkg::GeoW-1:0] geo_w = 12'd640;
  logic [ncb_pkg::GeoW-1:0] geo_h = 12'd480;
  logic                     skip_black = 1'b0;

  // Predicted stream state.
  logic [ncb_pkg::PixW-1:0] row_mem [ncb_pkg::MaxWidth];
  logic [ncb_pkg::PixW-1:0] left_px = '0;
  logic [ncb_pkg::PixW-1:0] upleft_px = '0;
  int unsigned              col_pos = 0;
  int unsigned              row_pos = 0;
  logic [ncb_pkg::SumW-1:0] sum_acc = '0;
  logic [ncb_pkg::CntW-1:0] pair_acc = '0;

  int          error_count = 0;
  int          feed_wait = 0;
  int          drain_hold = 0;
  bit          quiet_flow = 1'b0;
  int unsigned cycle_count = 0;

  function automatic int draw_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned clamp_geo(logic [ncb_pkg::GeoW-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned color_dist(logic [ncb_pkg::PixW-1:0] a,
                                             logic [ncb_pkg::PixW-1:0] b);
    int unsigned total;
    int d;
    total = 0;
    for (int k = 0; k < 3; k++) begin
      d = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
      total += d * d;
    end
    return total;
  endfunction

  function automatic void add_pair(logic [ncb_pkg::PixW-1:0] ctr, logic [ncb_pkg::PixW-1:0] nb);
    logic [ncb_pkg::SumW:0] s;
    if (skip_black && nb == '0) return;
    s = {1'b0, sum_acc} + color_dist(ctr, nb);
    sum_acc = s[ncb_pkg::SumW] ? '1 : s[ncb_pkg::SumW-1:0];
    if (pair_acc != '1) pair_acc++;
  endfunction

  // Advance the stream model by one pixel; a final pixel queues its beta result.
  function automatic void accumulate_pixel(ncb_pkg::pix_in_t p);
    logic [ncb_pkg::PixW-1:0] cur, up, upright;
    int unsigned w, h, x, y;
    logic [ncb_pkg::CntW+ncb_pkg::FracShift-1:0] scaled, quot;
    ncb_pkg::beta_out_t r;
    cur = {p.red, p.green, p.blue};
    w = clamp_geo(geo_w, ncb_pkg::MaxWidth);
    h = clamp_geo(geo_h, ncb_pkg::MaxHeight);
    x = col_pos;
    y = row_pos;
    up = (x < ncb_pkg::MaxWidth) ? row_mem[x] : '0;
    upright = (x + 1 < ncb_pkg::MaxWidth) ? row_mem[x + 1] : '0;
    if (cur != '0) begin
      if (x > 0) add_pair(cur, left_px);
      if (y > 0 && x > 0) add_pair(cur, upleft_px);
      if (y > 0) add_pair(cur, up);
      if (y > 0 && x + 1 < w) add_pair(cur, upright);
    end
    upleft_px = up;
    if (x < ncb_pkg::MaxWidth) row_mem[x] = cur;
    left_px = cur;
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
    if (p.final_pixel) begin
      r.pair_total     = pair_acc;
      r.squared_sum    = sum_acc;
      r.beta_value     = '0;
      r.beta_saturated = 1'b0;
      if (sum_acc != '0) begin
        scaled = {pair_acc, {ncb_pkg::FracShift{1'b0}}};
        quot = scaled / sum_acc;
        if (quot[ncb_pkg::CntW+ncb_pkg::FracShift-1:ncb_pkg::BetaW] != '0) begin
          r.beta_value     = '1;
          r.beta_saturated = 1'b1;
        end else begin
          r.beta_value = quot[ncb_pkg::BetaW-1:0];
        end
      end
      pending_betas.insert(pending_betas.size(), r);
      left_px   = '0;
      upleft_px = '0;
      col_pos   = 0;
      row_pos   = 0;
      sum_acc   = '0;
      pair_acc  = '0;
    end
  endfunction

  function automatic void flag_error(string what, logic [63:0] want, logic [63:0] got);
    error_count++;
    if (error_count <= 10)
      $display("mismatch %s: expected 0x%0h, got 0x%0h", what, want, got);
  endfunction

  function automatic void compare_beta(ncb_pkg::beta_out_t got);
    ncb_pkg::beta_out_t want;
    if (pending_betas.size() == 0) begin
      flag_error("result with none pending", '0, got.beta_value);
      return;
    end
    want = pending_betas.pop_front();
    if (got.beta_value !== want.beta_value)
      flag_error("beta_value", want.beta_value, got.beta_value);
    if (got.pair_total !== want.pair_total)
      flag_error("pair_total", want.pair_total, got.pair_total);
    if (got.squared_sum !== want.squared_sum)
      flag_error("squared_sum", want.squared_sum, got.squared_sum);
    if (got.beta_saturated !== want.beta_saturated)
      flag_error("beta_saturated", want.beta_saturated, got.beta_saturated);
  endfunction

  // Pixel driver: one transaction per accepted valid, random gaps between.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        accumulate_pixel(in_data_i);
        feed_wait = quiet_flow ? 0 : draw_gap();
      end
      if (!in_valid_i || in_ready_o) begin
        if (feed_wait == 0 && pixel_backlog.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pixel_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          if (feed_wait > 0) feed_wait--;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) compare_beta(out_data_o);
      if (drain_hold > 0) begin
        out_ready_i <= 1'b0;
        drain_hold--;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet_flow && $urandom_range(0, 2) == 0) drain_hold = draw_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_pixel(logic [ncb_pkg::PixW-1:0] c, logic fin);
    ncb_pkg::pix_in_t p;
    p.red         = c[23:16];
    p.green       = c[15:8];
    p.blue        = c[7:0];
    p.final_pixel = fin;
    pixel_backlog.insert(pixel_backlog.size(), p);
  endtask

  function automatic logic [ncb_pkg::PixW-1:0] pick_color(logic [ncb_pkg::PixW-1:0] prev);
    logic [ncb_pkg::PixW-1:0] c;
    int sel;
    sel = $urandom_range(0, 99);
    c = ncb_pkg::PixW'($urandom);
    if (sel < 15) begin
      c = '0;
    end else if (sel < 25) begin
      for (int k = 0; k < 3; k++) c[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else if (sel < 60) begin
      // small steps from the last color keep sums low and beta large
      for (int k = 0; k < 3; k++) c[8*k +: 8] = prev[8*k +: 8] + 8'($urandom_range(0, 4)) - 8'd2;
    end
    return c;
  endfunction

  // Wait for the block to drain, then let it settle.
  task automatic settle(int pause);
    do @(negedge clk_i);
    while (pixel_backlog.size() != 0 || in_valid_i || pending_betas.size() != 0);
    repeat (pause) @(posedge clk_i);
  endtask

  task automatic configure(logic [ncb_pkg::GeoW-1:0] w, logic [ncb_pkg::GeoW-1:0] h,
                           logic [ncb_pkg::GeoW-1:0] skip_word);
    settle(20);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= ncb_pkg::REG_WIDTH;
    cfg_wdata_i <= w;
    geo_w = w;
    @(posedge clk_i);
    cfg_idx_i   <= ncb_pkg::REG_HEIGHT;
    cfg_wdata_i <= h;
    geo_h = h;
    @(posedge clk_i);
    cfg_idx_i   <= ncb_pkg::REG_SKIP;
    cfg_wdata_i <= skip_word;
    skip_black = skip_word[0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [ncb_pkg::PixW-1:0] tone;
    logic [ncb_pkg::GeoW-1:0] w_word, h_word;
    int unsigned              frame, cap;
    int                       n, sel, random_items, sets_done;

    foreach (row_mem[i]) row_mem[i] = '0;
    random_items = 0;
    sets_done    = 0;
    tone         = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: single-pixel set, then a short row with a black pixel.
    queue_pixel(24'h0C2238, 1'b1);
    queue_pixel(24'hFFFFFF, 1'b0);
    queue_pixel(24'h000000, 1'b0);
    queue_pixel(24'hFF0000, 1'b0);
    queue_pixel(24'h00FF00, 1'b1);

    // 3x2 frame with a black middle column, with and without skipping black neighbors
    configure(12'd3, 12'd2, 12'd0);
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) configure(12'd3, 12'd2, 12'hFFF);
      queue_pixel(24'hFFFFFF, 1'b0);
      queue_pixel(24'h000000, 1'b0);
      queue_pixel(24'h00FF00, 1'b0);
      queue_pixel(24'h0000FF, 1'b0);
      queue_pixel(24'h000000, 1'b0);
      queue_pixel(24'hFF00FF, 1'b1);
    end

    // identical pixels: pairs counted, sum stays zero
    configure(12'd2, 12'd2, 12'd0);
    repeat (3) queue_pixel(24'h070707, 1'b0);
    queue_pixel(24'h070707, 1'b1);

    // zero geometry acts as one
    configure(12'd0, 12'd0, 12'd0);
    queue_pixel(24'h010203, 1'b0);
    queue_pixel(24'hC86432, 1'b0);
    queue_pixel(24'hFFFFFF, 1'b1);

    // oversize geometry clamps
    configure(12'hFFF, 12'hFFF, 12'd1);
    queue_pixel(24'h000000, 1'b0);
    queue_pixel(24'hFFFFFF, 1'b0);
    queue_pixel(24'h010101, 1'b0);
    queue_pixel(24'h000000, 1'b0);
    queue_pixel(24'h804020, 1'b1);

    // full-width row: width above the maximum wraps at the maximum
    configure(12'd3000, 12'd3, 12'd0);
    for (int i = 0; i < ncb_pkg::MaxWidth + 5; i++) begin
      tone = pick_color(tone);
      queue_pixel(tone, i == ncb_pkg::MaxWidth + 4);
    end

    // random image sets
    while (random_items < 800 || sets_done < 40) begin
      if ($urandom_range(0, 9) < 6) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          w_word = 12'($urandom_range(1, 12));
          h_word = 12'($urandom_range(1, 6));
        end else if (sel < 88) begin
          w_word = 12'($urandom_range(13, 80));
          h_word = 12'($urandom_range(1, 4));
        end else if (sel < 94) begin
          w_word = $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(2048, 4095));
          h_word = 12'($urandom_range(0, 4095));
        end else begin
          w_word = 12'($urandom_range(1, 6));
          h_word = $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(2048, 4095));
        end
        configure(w_word, h_word, 12'($urandom));
      end
      quiet_flow = ($urandom_range(0, 4) == 0);
      frame = clamp_geo(geo_w, ncb_pkg::MaxWidth) * clamp_geo(geo_h, ncb_pkg::MaxHeight);
      cap = (2 * frame > 80) ? 80 : 2 * frame;
      n = $urandom_range(1, cap);
      for (int i = 0; i < n; i++) begin
        tone = pick_color(tone);
        queue_pixel(tone, i == n - 1);
      end
      random_items += n;
      sets_done++;
    end

    settle(100);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
